FILE: rtl/qubit_state_vector_engine_core_defines.svh
// Assertion macros for the state-vector engine
`ifndef QUBIT_STATE_VECTOR_ENGINE_CORE_DEFINES_SVH
`define QUBIT_STATE_VECTOR_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTH
`define QSV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QSV_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QSV_ASSERT(label, clk, rst_n, prop, msg)
`define QSV_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: rtl/qsve_pkg.sv
`default_nettype none
package qsve_pkg;
  localparam int unsigned MaxQubitsDefault = 10;
  localparam int unsigned AmpWidthDefault  = 16;
  localparam logic [3:0]  QubitCountReset  = 4'd4;
  localparam logic [2:0] CmdReset   = 3'd0;
  localparam logic [2:0] CmdHadamard = 3'd1;
  localparam logic [2:0] CmdPauliX  = 3'd2;
  localparam logic [2:0] CmdCnot    = 3'd3;
  localparam logic [2:0] CmdMeasure = 3'd4;
  localparam logic [2:0] CmdRead    = 3'd5;
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadQubit = 2'd1;
  localparam logic [1:0] StatusSameQubit = 2'd2;
  localparam logic [31:0] InvSqrt2Q31 = 32'd1518500250;
endpackage
`default_nettype wire

FILE: rtl/qsve_ram.sv
`default_nettype none
module qsve_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/qubit_state_vector_engine_core.sv
`default_nettype none
`include "qubit_state_vector_engine_core_defines.svh"
// State-vector engine: amplitudes of up to MAX_QUBITS qubits in one RAM.
// Command channel: start_i with command and operands is taken when busy_o
// is low; exactly one transaction is returned per command, shown for one
// cycle with done_o high. The receiver cannot stall the result.
// Configuration: qubit_count_we_i writes qubit_count_i; the user must raise
// it only at an idle edge, as the block itself does not enforce this.
// Commands that walk the RAM use one read port and one write port, one
// access per cycle, driven by a single sequencer. Steps per command:
//   reset        whole memory cleared
//   H, X         read pair, write pair
//   CNOT         as X, pairs without the control bit skipped
//   measure      sum pass, shift-add product for the threshold, search pass,
//                collapse pass; at zero total sum pass then collapse pass
//   read         one RAM read; bad operands answered straight from idle
// One command at a time; busy_o stays high until the strobe has gone.
// Reset clears the control state and runs a clearing pass over all DEPTH
// entries that loads the ground state; busy_o is high during that pass
// and no result follows it.
module qubit_state_vector_engine_core #(
  parameter int unsigned MAX_QUBITS = qsve_pkg::MaxQubitsDefault,
  parameter int unsigned AMP_WIDTH  = qsve_pkg::AmpWidthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  qubit_count_we_i,
  input  wire logic [3:0]            qubit_count_i,
  input  wire logic                  start_i,
  input  wire logic [2:0]            command_i,
  input  wire logic [3:0]            qubit_a_i,
  input  wire logic [3:0]            qubit_b_i,
  input  wire logic [MAX_QUBITS-1:0] amp_index_i,
  input  wire logic [15:0]           random_fraction_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic signed [15:0]         amp_real_o,
  output logic signed [15:0]         amp_imag_o,
  output logic [MAX_QUBITS-1:0]      outcome_o
);
  import qsve_pkg::*;

  localparam int unsigned AW = MAX_QUBITS;
  localparam int unsigned Depth = 1 << MAX_QUBITS;
  localparam int unsigned W = AMP_WIDTH;
  localparam int unsigned PW = 2 * W + 1 + AW;  // sum of squares width
  localparam int unsigned SqShift = (W > 16) ? 2 * (W - 16) : 0;
  localparam int unsigned PrW = PW + 16;        // product width
  localparam logic [W-1:0] AmpOne = W'(1) << (W - 2);
  localparam logic signed [W-1:0] AmpMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] AmpMin = {1'b1, {(W-1){1'b0}}};

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StClear   = 4'd1;
  localparam logic [3:0] StRdA     = 4'd2;
  localparam logic [3:0] StRdB     = 4'd3;
  localparam logic [3:0] StWrA     = 4'd4;
  localparam logic [3:0] StWrB     = 4'd5;
  localparam logic [3:0] StSum     = 4'd6;
  localparam logic [3:0] StMul     = 4'd7;
  localparam logic [3:0] StSearch  = 4'd8;
  localparam logic [3:0] StCollapse = 4'd9;
  localparam logic [3:0] StRead    = 4'd10;
  localparam logic [3:0] StReadOut = 4'd11;
  localparam logic [3:0] StMulAdd  = 4'd12;

  logic [3:0] state_q, state_d;
  logic [3:0] qcount_q;
  logic [2:0] cmd_q;
  logic [3:0] qa_q, qb_q;
  logic [15:0] rf_q;
  logic [AW:0] cnt_q, cnt_d;        // pair or entry counter
  logic [AW:0] rcnt_q, rcnt_d;      // read address counter in passes
  logic [AW-1:0] ai_q;
  logic [2*W-1:0] a_q, a_d;
  logic [PW-1:0] sum_q, sum_d, cum_q, cum_d;
  logic [PrW-1:0] prod_q, prod_d;
  logic [PW-1:0] mcand_q, mcand_d;
  logic [15:0] mplier_q, mplier_d;
  logic [4:0] mcnt_q, mcnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic found_q, found_d;
  logic rvalid_q;
  logic boot_q;
  logic take;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [2*W-1:0] ram_wdata, ram_rdata;

  qsve_ram #(.Width(2 * W), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // effective qubit count
  logic [3:0] nq;
  always_comb begin
    if (qcount_q == 4'd0) begin
      nq = 4'd1;
    end else if (32'(qcount_q) > MAX_QUBITS) begin
      nq = 4'(MAX_QUBITS);
    end else begin
      nq = qcount_q;
    end
  end
  logic [AW:0] dim;
  assign dim = (AW+1)'(1) << nq;

  // pair address: insert a zero at the target bit tq (qb for CNOT, else qa) into counter
  function automatic logic [AW-1:0] ins_zero(input logic [AW:0] c, input logic [3:0] q);
    logic [AW-1:0] low, res;
    low = (AW)'((AW'(1) << q) - AW'(1));
    res = (AW'(c) & low) | ((AW'(c) & ~low) << 1);
    return res;
  endfunction

  logic [3:0] tq;
  assign tq = (cmd_q == CmdCnot) ? qb_q : qa_q;
  logic [AW-1:0] pa, pb;
  assign pa = ins_zero(cnt_q, tq);
  assign pb = pa | (AW'(1) << tq);
  logic pair_on;
  assign pair_on = (cmd_q != CmdCnot) || pa[qa_q];

  // scaled butterfly half
  function automatic logic [W-1:0] scale_half(input logic signed [W:0] v);
    logic signed [W+32:0] p;
    logic [W+32:0] m;
    logic [W+32:0] r;
    logic signed [W+33:0] s;
    p = $signed({{32{v[W]}}, v}) * $signed({1'b0, InvSqrt2Q31});
    m = p[W+32] ? (W+33)'(-p) : (W+33)'(p);
    r = (m + (W+33)'(33'd1 << 30)) >> 31;
    s = p[W+32] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (s > $signed((W+34)'(AmpMax))) begin
      return AmpMax;
    end else if (s < $signed({{34{1'b1}}, AmpMin})) begin
      return AmpMin;
    end
    return s[W-1:0];
  endfunction

  logic signed [W-1:0] are, aim, bre, bim;
  assign are = a_q[2*W-1:W];
  assign aim = a_q[W-1:0];
  assign bre = ram_rdata[2*W-1:W];
  assign bim = ram_rdata[W-1:0];
  logic [2*W-1:0] hdif_q;
  logic [2*W-1:0] hsum_d, hdif_d;
  always_comb begin
    hsum_d = {scale_half($signed({are[W-1], are}) + $signed({bre[W-1], bre})),
              scale_half($signed({aim[W-1], aim}) + $signed({bim[W-1], bim}))};
    hdif_d = {scale_half($signed({are[W-1], are}) - $signed({bre[W-1], bre})),
              scale_half($signed({aim[W-1], aim}) - $signed({bim[W-1], bim}))};
  end

  // probability of the registered read word
  logic [W-1:0] absr, absi;
  logic [PW-1:0] prob;
  assign absr = bre[W-1] ? W'(-bre) : W'(bre);
  assign absi = bim[W-1] ? W'(-bim) : W'(bim);
  logic [2*W-1:0] sqr_q, sqi_q;
  logic sq_valid_q;
  always_ff @(posedge clk_i) begin
    sqr_q <= absr * absr;
    sqi_q <= absi * absi;
  end
  assign prob = PW'(({1'b0, sqr_q} + {1'b0, sqi_q}) >> SqShift);

  logic res_v;
  logic [1:0] res_st;
  logic [W-1:0] res_re, res_im;
  logic [AW-1:0] res_out;

  assign take = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    rcnt_d = rcnt_q;
    a_d = a_q;
    sum_d = sum_q;
    cum_d = cum_q;
    prod_d = prod_q;
    mcand_d = mcand_q;
    mplier_d = mplier_q;
    mcnt_d = mcnt_q;
    idx_d = idx_q;
    found_d = found_q;
    ram_we = 1'b0;
    ram_waddr = AW'(cnt_q);
    ram_wdata = '0;
    ram_raddr = pa;
    res_v = 1'b0;
    res_st = StatusOk;
    res_re = '0;
    res_im = '0;
    res_out = '0;
    case (state_q)
      StIdle: begin
        cnt_d = '0;
        rcnt_d = '0;
        if (take) begin
          case (command_i)
            CmdReset: state_d = StClear;
            CmdHadamard, CmdPauliX: begin
              if (qubit_a_i >= nq) begin
                res_v = 1'b1;
                res_st = StatusBadQubit;
              end else begin
                state_d = StRdA;
              end
            end
            CmdCnot: begin
              if (qubit_a_i >= nq || qubit_b_i >= nq) begin
                res_v = 1'b1;
                res_st = StatusBadQubit;
              end else if (qubit_a_i == qubit_b_i) begin
                res_v = 1'b1;
                res_st = StatusSameQubit;
              end else begin
                state_d = StRdA;
              end
            end
            CmdMeasure: begin
              state_d = StSum;
              sum_d = '0;
            end
            CmdRead: begin
              if ((AW+1)'(amp_index_i) >= dim) begin
                res_v = 1'b1;
                res_st = StatusBadQubit;
              end else begin
                state_d = StRead;
              end
            end
            default: res_v = 1'b1;
          endcase
        end
      end
      StClear: begin
        ram_we = 1'b1;
        ram_wdata = (cnt_q == '0) ? {AmpOne, {W{1'b0}}} : '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(Depth - 1)) begin
          state_d = StIdle;
          res_v = !boot_q;
        end
      end
      StRdA: begin
        if (cnt_q == dim >> 1) begin
          state_d = StIdle;
          res_v = 1'b1;
        end else if (!pair_on) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          ram_raddr = pa;
          state_d = StRdB;
        end
      end
      StRdB: begin
        ram_raddr = pb;
        a_d = ram_rdata;
        state_d = StWrA;
      end
      StWrA: begin
        ram_we = 1'b1;
        ram_waddr = pa;
        ram_wdata = (cmd_q == CmdHadamard) ? hsum_d : ram_rdata;
        state_d = StWrB;
      end
      StWrB: begin
        ram_we = 1'b1;
        ram_waddr = pb;
        ram_wdata = (cmd_q == CmdHadamard) ? hdif_q : a_q;
        cnt_d = cnt_q + 1'b1;
        state_d = StRdA;
      end
      StSum, StSearch: begin
        // read at rcnt, RAM output register, square register, accumulate at cnt
        ram_raddr = AW'(rcnt_q);
        if (rcnt_q != dim) begin
          rcnt_d = rcnt_q + 1'b1;
        end
        if (sq_valid_q) begin
          cnt_d = cnt_q + 1'b1;
          if (state_q == StSum) begin
            sum_d = sum_q + prob;
          end else if (!found_q) begin
            cum_d = cum_q + prob;
            if ({cum_q + prob, 16'd0} >= prod_q) begin
              found_d = 1'b1;
              idx_d = AW'(cnt_q);
            end
          end
        end
        if (cnt_q == dim) begin
          cnt_d = '0;
          rcnt_d = '0;
          if (state_q == StSum) begin
            if (sum_q == '0) begin
              idx_d = '0;
              state_d = StCollapse;
            end else begin
              mcand_d = sum_q;
              mplier_d = rf_q;
              prod_d = '0;
              mcnt_d = '0;
              state_d = StMul;
            end
          end else begin
            if (!found_q) begin
              idx_d = AW'(dim - 1'b1);
            end
            state_d = StCollapse;
          end
        end
      end
      StMul: begin
        // shift-add product rf * sum, one multiplier bit per pass through StMul and StMulAdd
        if (mplier_q[0]) begin
          prod_d = prod_q + PrW'(mcand_q);
        end
        mcand_d = mcand_q;
        mplier_d = mplier_q >> 1;
        state_d = StMulAdd;
      end
      StMulAdd: begin
        mcand_d = mcand_q;
        prod_d = prod_q;
        mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == 5'd15) begin
          // prod holds sum * rf after realignment
          state_d = StSearch;
          cum_d = '0;
          found_d = 1'b0;
        end else begin
          state_d = StMul;
        end
      end
      StCollapse: begin
        ram_we = 1'b1;
        ram_waddr = AW'(cnt_q);
        ram_wdata = (AW'(cnt_q) == idx_q) ? {AmpOne, {W{1'b0}}} : '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == dim - 1'b1) begin
          state_d = StIdle;
          res_v = 1'b1;
          res_out = idx_q;
        end
      end
      StRead: begin
        ram_raddr = ai_q;
        state_d = StReadOut;
      end
      StReadOut: begin
        ram_raddr = ai_q;
        state_d = StIdle;
        res_v = 1'b1;
        res_re = bre;
        res_im = bim;
      end
      default: state_d = StIdle;
    endcase
  end

  // product accumulates with the multiplicand weight shifting up
  logic [PrW-1:0] mprod_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) begin
      mprod_q <= '0;
    end else if (state_q == StMul) begin
      if (mplier_q[0]) begin
        mprod_q <= mprod_q + (PrW'(sum_q) << mcnt_q[3:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      qcount_q <= QubitCountReset;
      cmd_q <= CmdReset;
      cnt_q <= '0;
      rcnt_q <= '0;
      sq_valid_q <= 1'b0;
      rvalid_q <= 1'b0;
      found_q <= 1'b0;
      done_o <= 1'b0;
      mcnt_q <= '0;
      boot_q <= 1'b1;
    end else begin
      if (qubit_count_we_i) begin
        qcount_q <= qubit_count_i;
      end
      if (take) begin
        cmd_q <= command_i;
      end
      if (state_q == StClear && state_d == StIdle) begin
        boot_q <= 1'b0;
      end
      state_q <= state_d;
      cnt_q <= cnt_d;
      rcnt_q <= rcnt_d;
      rvalid_q <= ((state_q == StSum) || (state_q == StSearch)) && (rcnt_q != dim);
      sq_valid_q <= rvalid_q && ((state_q == StSum) || (state_q == StSearch))
                    && (cnt_q != dim);
      found_q <= found_d;
      done_o <= res_v;
      mcnt_q <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      qa_q <= qubit_a_i;
      qb_q <= qubit_b_i;
      rf_q <= random_fraction_i;
      ai_q <= amp_index_i;
    end
    a_q <= a_d;
    hdif_q <= hdif_d;
    sum_q <= sum_d;
    cum_q <= cum_d;
    prod_q <= (state_q == StMulAdd && mcnt_q == 5'd15) ? mprod_q : prod_d;
    mcand_q <= mcand_d;
    mplier_q <= mplier_d;
    idx_q <= idx_d;
    status_o <= res_st;
    amp_real_o <= 16'(res_re);
    amp_imag_o <= 16'(res_im);
    outcome_o <= res_out;
  end

  assign busy_o = (state_q != StIdle) || done_o;

  `QSV_ASSERT(a_done_from_idle_or_end, clk_i, rst_ni,
    done_o |-> $past(state_q) != StRdB && $past(state_q) != StWrA,
    "result strobe in mid pair")
  `QSV_ASSERT(a_no_write_idle, clk_i, rst_ni, (state_q == StIdle) |-> !ram_we,
    "memory written while idle")
  `QSV_ASSERT(a_single_done, clk_i, rst_ni, done_o |=> !done_o,
    "result strobe longer than one cycle")
  `QSV_ASSERT(a_measure_idx, clk_i, rst_ni,
    (state_q == StCollapse) |-> ((AW+1)'(idx_q) < dim),
    "measured index beyond dimension")
endmodule
`default_nettype wire
